FILE: sv/stable_index_sort_macros.svh
// Assertion macros for the stable index sort block.
// Expects clk and arst_n in the scope of each use.
`ifndef STABLE_INDEX_SORT_MACROS_SVH
`define STABLE_INDEX_SORT_MACROS_SVH

`ifndef SYNTHESIS
// Plain invariant, checked at every edge outside reset.
`define SIS_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("stable_index_sort: invariant violated");
// Same-cycle implication.
`define SIS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stable_index_sort: implication violated");
// Next-cycle implication.
`define SIS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stable_index_sort: next-cycle check violated");
`else
`define SIS_ASSERT(lbl, cond)
`define SIS_ASSERT_IMP(lbl, ante, cons)
`define SIS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: sv/sis_pkg.sv
// Shared constants, codes, cell control type and key ordering functions
// for the stable index sort block. No dependencies.
package sis_pkg;

	localparam int SIS_MAX_ROWS = 1024;
	localparam int KEY_W        = 32;
	localparam int ROW_OUT_W    = 10;
	localparam int FMT_W        = 3;
	localparam int CFG_ADDR_W   = 3;
	localparam int CFG_DATA_W   = 32;

	// key formats
	localparam logic [FMT_W-1:0] FMT_S16 = 3'd0;
	localparam logic [FMT_W-1:0] FMT_U16 = 3'd1;
	localparam logic [FMT_W-1:0] FMT_S32 = 3'd2;
	localparam logic [FMT_W-1:0] FMT_U32 = 3'd3;
	localparam logic [FMT_W-1:0] FMT_U8  = 3'd4;

	localparam logic [FMT_W-1:0] FMT_RESET = FMT_S32;
	localparam logic             ASC_RESET = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_KEY_FORMAT = 1'b0;
	localparam logic REG_ASCENDING  = 1'b1;

	// command kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic clear;
		logic insert;
		logic shift;
	} cell_ctl_t;

	// Map a raw key to an unsigned value that orders as the key does.
	function automatic logic [KEY_W-1:0] order_value(input logic [KEY_W-1:0] k,
			input logic [FMT_W-1:0] fmt);
		logic [KEY_W-1:0] v;
		case (fmt)
			FMT_S16: v = {16'h0000, k[15:0] ^ 16'h8000};
			FMT_U16: v = {16'h0000, k[15:0]};
			FMT_S32: v = k ^ 32'h8000_0000;
			FMT_U8:  v = {24'h000000, k[7:0]};
			default: v = k;
		endcase
		return v;
	endfunction

	// Recover the masked raw key from its order value.
	function automatic logic [KEY_W-1:0] key_of_order(input logic [KEY_W-1:0] v,
			input logic [FMT_W-1:0] fmt);
		logic [KEY_W-1:0] k;
		case (fmt)
			FMT_S16: k = v ^ 32'h0000_8000;
			FMT_S32: k = v ^ 32'h8000_0000;
			default: k = v;
		endcase
		return k;
	endfunction

endpackage

FILE: sv/sis_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: sv/sis_cell.sv
// One cell of the insertion chain: holds an order value and its row.
// Depends on sis_pkg.
module sis_cell #(
	parameter int ROW_W = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sis_pkg::cell_ctl_t       ctl,
	input  logic [sis_pkg::KEY_W-1:0] new_ov,
	input  logic [ROW_W-1:0]         new_row,
	input  logic                     prev_gt,
	input  logic                     prev_valid,
	input  logic [sis_pkg::KEY_W-1:0] prev_ov,
	input  logic [ROW_W-1:0]         prev_row,
	input  logic                     next_valid,
	input  logic [sis_pkg::KEY_W-1:0] next_ov,
	input  logic [ROW_W-1:0]         next_row,
	output logic                     valid,
	output logic [sis_pkg::KEY_W-1:0] ov,
	output logic [ROW_W-1:0]         row,
	output logic                     gt
);
	import sis_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] ov_q;
	logic [ROW_W-1:0] row_q;

	// strictly greater keeps equal keys ahead of the newcomer
	assign gt    = !valid_q || (ov_q > new_ov);
	assign valid = valid_q;
	assign ov    = ov_q;
	assign row   = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			if (prev_gt) begin
				valid_q <= prev_valid;
			end else if (gt) begin
				valid_q <= 1'b1;
			end
		end else if (ctl.shift) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			// take the left neighbour when the newcomer lands further left
			if (prev_gt) begin
				ov_q  <= prev_ov;
				row_q <= prev_row;
			end else if (gt) begin
				ov_q  <= new_ov;
				row_q <= new_row;
			end
		end else if (ctl.shift) begin
			ov_q  <= next_ov;
			row_q <= next_row;
		end
	end

endmodule

FILE: sv/stable_index_sort.sv
// Stable index sort: load keys, then read them back in sorted order with rows.
//
// Command channel (cmd_valid/cmd_stall): kind 0 loads key_bits as the next row,
// end_of_set closes the set; kind 1 reads the next sorted entry. A beat is taken
// when cmd_valid is high and cmd_stall low. Loads give no result; a load
// after a closed set starts a new one. Keys past MAX_ROWS are
// dropped and set the sticky overflowed flag.
// Result channel (res_valid/res_stall): one beat per read, held in an output
// register until taken. A read of an open set or past the end returns
// none_left through ST_NONE, with no rebuild of the order.
// The first read after a load or a key_format write rebuilds the order: the
// keys stream out of the key memory, one per cycle, into a chain of MAX_ROWS
// insertion cells, then shift out into the sorted memory. Later reads skip the
// rebuild and pass through ST_FETCH and ST_RDATA, the registered read of the
// sorted memory, before the result reaches the output register.
// Registers on the APB port: key_format at 0x0, ascending at 0x4.
// Reset clears the set, the flag and the result register; memories need no
// clearing. While res_stall holds a finished result, the next command is
// taken only after that result has moved into the output register.
`include "stable_index_sort_macros.svh"

module stable_index_sort #(
	parameter int MAX_ROWS = sis_pkg::SIS_MAX_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic                          kind,
	input  logic [sis_pkg::KEY_W-1:0]     key_bits,
	input  logic                          end_of_set,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [sis_pkg::KEY_W-1:0]     sorted_key,
	output logic [sis_pkg::ROW_OUT_W-1:0] source_row,
	output logic                          last_entry,
	output logic                          none_left,
	output logic                          overflowed,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sis_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [sis_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [sis_pkg::CFG_DATA_W-1:0] prdata,
	output logic                          pready
);
	import sis_pkg::*;

	localparam int AW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_ROWS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_UNLOAD,
		ST_FETCH,
		ST_RDATA,
		ST_NONE
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    read_pos_q;
	logic [CW-1:0]    step_q;
	logic             closed_q;
	logic             ovf_q;
	logic             order_ok_q;
	logic [FMT_W-1:0] fmt_q;
	logic             asc_q;
	logic             fill_vld_s1;
	logic [AW-1:0]    fill_row_s1;

	logic                 res_valid_q;
	logic [KEY_W-1:0]     res_key_q;
	logic [ROW_OUT_W-1:0] res_row_q;
	logic                 res_last_q;
	logic                 res_none_q;
	logic                 res_ovf_q;

	logic             cmd_fire;
	logic             load_fire;
	logic             read_fire;
	logic             cfg_wr;
	logic [CW-1:0]    base_cnt;
	logic             room;
	logic             read_ok;
	logic             out_free;
	logic [CW-1:0]    pos_full;
	logic             key_rd_en;
	logic [KEY_W-1:0] key_rd;
	logic [KEY_W-1:0] new_ov;
	logic [KEY_W+AW-1:0] srt_rd;
	cell_ctl_t        cell_ctl;

	logic             c_valid [0:MAX_ROWS+1];
	logic [KEY_W-1:0] c_ov    [0:MAX_ROWS+1];
	logic [AW-1:0]    c_row   [0:MAX_ROWS+1];
	logic             gt_link [0:MAX_ROWS];

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign load_fire = cmd_fire && (kind == KIND_LOAD);
	assign read_fire = cmd_fire && (kind == KIND_READ);
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;

	assign base_cnt  = closed_q ? '0 : count_q;
	assign room      = base_cnt < CW'(MAX_ROWS);
	assign read_ok   = closed_q && (read_pos_q < count_q);
	assign out_free  = !res_valid_q || !res_stall;
	assign pos_full  = asc_q ? read_pos_q : (count_q - 1'b1 - read_pos_q);
	assign key_rd_en = (state_q == ST_FILL) && (step_q < count_q);
	assign new_ov    = order_value(key_rd, fmt_q);

	assign cell_ctl.clear  = read_fire && read_ok && !order_ok_q;
	assign cell_ctl.insert = fill_vld_s1;
	assign cell_ctl.shift  = (state_q == ST_UNLOAD);

	always_comb begin
		case (paddr[2])
			REG_KEY_FORMAT: prdata = CFG_DATA_W'(fmt_q);
			REG_ASCENDING:  prdata = CFG_DATA_W'(asc_q);
		endcase
	end

	sis_ram #(
		.WIDTH(KEY_W),
		.DEPTH(MAX_ROWS)
	) u_key_ram (
		.clk    (clk),
		.wr_en  (load_fire && room),
		.wr_addr(base_cnt[AW-1:0]),
		.wr_data(key_bits),
		.rd_en  (key_rd_en),
		.rd_addr(step_q[AW-1:0]),
		.rd_data(key_rd)
	);

	sis_ram #(
		.WIDTH(KEY_W + AW),
		.DEPTH(MAX_ROWS)
	) u_sorted_ram (
		.clk    (clk),
		.wr_en  (state_q == ST_UNLOAD),
		.wr_addr(step_q[AW-1:0]),
		.wr_data({c_ov[1], c_row[1]}),
		.rd_en  (state_q == ST_FETCH),
		.rd_addr(pos_full[AW-1:0]),
		.rd_data(srt_rd)
	);

	// chain ends: nothing to the left of the first cell or right of the last
	assign c_valid[0]          = 1'b0;
	assign c_ov[0]             = '0;
	assign c_row[0]            = '0;
	assign c_valid[MAX_ROWS+1] = 1'b0;
	assign c_ov[MAX_ROWS+1]    = '0;
	assign c_row[MAX_ROWS+1]   = '0;
	assign gt_link[0]          = 1'b0;

	for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
		sis_cell #(
			.ROW_W(AW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl),
			.new_ov    (new_ov),
			.new_row   (fill_row_s1),
			.prev_gt   (gt_link[i]),
			.prev_valid(c_valid[i]),
			.prev_ov   (c_ov[i]),
			.prev_row  (c_row[i]),
			.next_valid(c_valid[i+2]),
			.next_ov   (c_ov[i+2]),
			.next_row  (c_row[i+2]),
			.valid     (c_valid[i+1]),
			.ov        (c_ov[i+1]),
			.row       (c_row[i+1]),
			.gt        (gt_link[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			read_pos_q  <= '0;
			step_q      <= '0;
			closed_q    <= 1'b0;
			ovf_q       <= 1'b0;
			order_ok_q  <= 1'b0;
			fmt_q       <= FMT_RESET;
			asc_q       <= ASC_RESET;
			fill_vld_s1 <= 1'b0;
			fill_row_s1 <= '0;
			res_valid_q <= 1'b0;
			res_key_q   <= '0;
			res_row_q   <= '0;
			res_last_q  <= 1'b0;
			res_none_q  <= 1'b0;
			res_ovf_q   <= 1'b0;
		end else begin
			fill_vld_s1 <= key_rd_en;
			fill_row_s1 <= step_q[AW-1:0];

			if (cfg_wr) begin
				case (paddr[2])
					REG_KEY_FORMAT: begin
						fmt_q      <= pwdata[FMT_W-1:0];
						order_ok_q <= 1'b0;
					end
					REG_ASCENDING: begin
						asc_q <= pwdata[0];
					end
				endcase
			end

			// drop a taken beat unless a new one lands this cycle
			if (!res_stall && state_q != ST_RDATA && state_q != ST_NONE) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (load_fire) begin
						if (closed_q) begin
							read_pos_q <= '0;
						end
						if (room) begin
							count_q <= base_cnt + 1'b1;
						end else begin
							count_q <= base_cnt;
							ovf_q   <= 1'b1;
						end
						closed_q   <= end_of_set;
						order_ok_q <= 1'b0;
					end
					if (read_fire) begin
						if (!read_ok) begin
							state_q <= ST_NONE;
						end else if (order_ok_q) begin
							state_q <= ST_FETCH;
						end else begin
							step_q  <= '0;
							state_q <= ST_FILL;
						end
					end
				end
				ST_FILL: begin
					// last key lands in the chain on the cycle that leaves
					if (step_q < count_q) begin
						step_q <= step_q + 1'b1;
					end else begin
						step_q  <= '0;
						state_q <= ST_UNLOAD;
					end
				end
				ST_UNLOAD: begin
					step_q <= step_q + 1'b1;
					if (step_q == count_q - 1'b1) begin
						order_ok_q <= 1'b1;
						state_q    <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_RDATA;
				end
				ST_RDATA: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_key_q   <= key_of_order(srt_rd[KEY_W+AW-1:AW], fmt_q);
						res_row_q   <= ROW_OUT_W'(srt_rd[AW-1:0]);
						res_last_q  <= (read_pos_q + 1'b1) == count_q;
						res_none_q  <= 1'b0;
						res_ovf_q   <= ovf_q;
						read_pos_q  <= read_pos_q + 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_NONE: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_key_q   <= '0;
						res_row_q   <= '0;
						res_last_q  <= 1'b0;
						res_none_q  <= 1'b1;
						res_ovf_q   <= ovf_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid  = res_valid_q;
	assign sorted_key = res_key_q;
	assign source_row = res_row_q;
	assign last_entry = res_last_q;
	assign none_left  = res_none_q;
	assign overflowed = res_ovf_q;

	// an insert never pushes a held key off the end of the chain
	`SIS_ASSERT_IMP(a_insert_room, cell_ctl.insert, gt_link[MAX_ROWS])
	// the head cell holds a key for every beat written to the sorted memory
	`SIS_ASSERT_IMP(a_unload_valid, state_q == ST_UNLOAD, c_valid[1])
	// keys leave the chain in non-decreasing order
	`SIS_ASSERT_NXT(a_unload_order, state_q == ST_UNLOAD && step_q != count_q - 1'b1, c_ov[1] >= $past(c_ov[1]))
	`SIS_ASSERT_IMP(a_none_blank, res_valid && none_left, sorted_key == '0 && source_row == '0 && !last_entry)
	`SIS_ASSERT(a_pos_bound, read_pos_q <= count_q)

endmodule

FILE: verif/stable_index_sort_test.sv
// Self-checking testbench for stable_index_sort: loads key sets, reads them back
// and checks every result beat against a predictor kept inside the bench.
// Depends on sis_pkg and the stable_index_sort RTL only.
module stable_index_sort_test;
	import sis_pkg::*;

	localparam int ROWS        = SIS_MAX_ROWS;
	localparam int QUIET_LIMIT = 10000;
	localparam int RANDOM_GOAL = 720;

	typedef struct {
		logic             op;
		logic [KEY_W-1:0] bits;
		logic             closes;
		bit               wait_drain;
	} cmd_beat_t;

	typedef struct {
		logic [KEY_W-1:0]     key;
		logic [ROW_OUT_W-1:0] row;
		logic                 last;
		logic                 none;
		logic                 ovf;
	} entry_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                   cmd_valid  = 1'b0;
	logic                   kind       = KIND_LOAD;
	logic [KEY_W-1:0]       key_bits   = '0;
	logic                   end_of_set = 1'b0;
	logic                   res_stall  = 1'b0;
	logic                   psel       = 1'b0;
	logic                   penable    = 1'b0;
	logic                   pwrite     = 1'b0;
	logic [CFG_ADDR_W-1:0]  paddr      = '0;
	logic [CFG_DATA_W-1:0]  pwdata     = '0;

	logic                   cmd_stall;
	logic                   res_valid;
	logic [KEY_W-1:0]       sorted_key;
	logic [ROW_OUT_W-1:0]   source_row;
	logic                   last_entry;
	logic                   none_left;
	logic                   overflowed;
	logic [CFG_DATA_W-1:0]  prdata;
	logic                   pready;

	stable_index_sort #(
		.MAX_ROWS(ROWS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.kind(kind),
		.key_bits(key_bits),
		.end_of_set(end_of_set),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.sorted_key(sorted_key),
		.source_row(source_row),
		.last_entry(last_entry),
		.none_left(none_left),
		.overflowed(overflowed),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// predictor state
	logic [KEY_W-1:0] kept_keys [ROWS];
	int               sort_index [ROWS];
	int               kept_count   = 0;
	int               next_read    = 0;
	bit               set_done     = 1'b0;
	bit               dropped_any  = 1'b0;
	bit               order_fresh  = 1'b0;
	logic [FMT_W-1:0] cfg_fmt      = FMT_RESET;
	bit               cfg_asc      = ASC_RESET;

	cmd_beat_t backlog [$];
	entry_t    due_entries [$];
	cmd_beat_t cur_beat;

	int  reads_sent    = 0;
	int  results_taken = 0;
	int  beats_queued  = 0;
	int  fault_count   = 0;
	int  quiet_cycles  = 0;
	int  drive_gap     = 0;
	int  hold_left     = 0;
	bit  drive_calm    = 1'b0;
	bit  take_calm     = 1'b0;

	function automatic logic [KEY_W-1:0] fmt_mask(logic [FMT_W-1:0] f);
		case (f)
			FMT_S16, FMT_U16: return 32'h0000_FFFF;
			FMT_U8:           return 32'h0000_00FF;
			default:          return 32'hFFFF_FFFF;
		endcase
	endfunction

	// True when key a sorts strictly after key b in the current format.
	function automatic bit ranks_above(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
		case (cfg_fmt)
			FMT_S16: return $signed(a[15:0]) > $signed(b[15:0]);
			FMT_U16: return a[15:0] > b[15:0];
			FMT_S32: return $signed(a) > $signed(b);
			FMT_U8:  return a[7:0] > b[7:0];
			default: return a > b;
		endcase
	endfunction

	function automatic void rank_held_keys();
		int i;
		int j;
		for (i = 0; i < kept_count; i++) begin
			j = i;
			// strict compare keeps equal keys in arrival order
			while (j > 0 && ranks_above(kept_keys[sort_index[j-1]], kept_keys[i])) begin
				sort_index[j] = sort_index[j-1];
				j--;
			end
			sort_index[j] = i;
		end
		order_fresh = 1'b1;
	endfunction

	function automatic void predict_sorted_entry(cmd_beat_t b);
		entry_t e;
		int     pos;
		int     idx;
		if (b.op == KIND_LOAD) begin
			if (set_done) begin
				kept_count = 0;
				next_read  = 0;
				set_done   = 1'b0;
			end
			if (kept_count < ROWS) begin
				kept_keys[kept_count] = b.bits;
				kept_count++;
			end else begin
				dropped_any = 1'b1;
			end
			if (b.closes)
				set_done = 1'b1;
			order_fresh = 1'b0;
			return;
		end
		e.key  = '0;
		e.row  = '0;
		e.last = 1'b0;
		e.none = 1'b0;
		e.ovf  = dropped_any;
		if (!set_done || next_read >= kept_count) begin
			e.none = 1'b1;
		end else begin
			if (!order_fresh)
				rank_held_keys();
			pos   = cfg_asc ? next_read : kept_count - 1 - next_read;
			idx   = sort_index[pos];
			e.key = kept_keys[idx] & fmt_mask(cfg_fmt);
			e.row = idx[ROW_OUT_W-1:0];
			next_read++;
			e.last = (next_read == kept_count);
		end
		due_entries.push_back(e);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		fault_count++;
		if (fault_count <= 100)
			$display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $time);
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin : drive_beats
		bit took;
		int in_flight;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			drive_gap = 0;
		end else begin
			took      = cmd_valid && !cmd_stall;
			in_flight = reads_sent - results_taken;
			if (took) begin
				predict_sorted_entry(cur_beat);
				if (cur_beat.op == KIND_READ) begin
					reads_sent <= reads_sent + 1;
					in_flight++;
				end
				if ($urandom_range(0, 63) == 0)
					drive_calm = !drive_calm;
				drive_gap = drive_calm ? 0 : $urandom_range(0, 15);
			end
			if (cmd_valid && !took) begin
				// hold the stalled beat
			end else if (drive_gap > 0) begin
				cmd_valid <= 1'b0;
				drive_gap--;
			end else if (backlog.size() > 0 &&
					(!backlog[0].wait_drain || in_flight == 0)) begin
				cur_beat = backlog.pop_front();
				cmd_valid  <= 1'b1;
				kind       <= cur_beat.op;
				key_bits   <= cur_beat.bits;
				end_of_set <= cur_beat.closes;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : watch_results
		entry_t want;
		bit     took;
		if (!arst_n) begin
			res_stall <= 1'b0;
			hold_left = 0;
		end else begin
			took = res_valid && !res_stall;
			if (took) begin
				results_taken <= results_taken + 1;
				if (due_entries.size() == 0) begin
					report_mismatch("result with no read outstanding", sorted_key, 0);
				end else begin
					want = due_entries.pop_front();
					if (sorted_key !== want.key)
						report_mismatch("sorted_key", sorted_key, want.key);
					if (source_row !== want.row)
						report_mismatch("source_row", 32'(source_row), 32'(want.row));
					if (last_entry !== want.last)
						report_mismatch("last_entry", 32'(last_entry), 32'(want.last));
					if (none_left !== want.none)
						report_mismatch("none_left", 32'(none_left), 32'(want.none));
					if (overflowed !== want.ovf)
						report_mismatch("overflowed", 32'(overflowed), 32'(want.ovf));
				end
				if ($urandom_range(0, 63) == 0)
					take_calm = !take_calm;
				hold_left = take_calm ? 0 : $urandom_range(0, 15);
			end else if (res_valid && hold_left > 0) begin
				hold_left--;
			end
			res_stall <= (hold_left > 0) ||
				(!res_valid && !take_calm && $urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
				(psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic push_beat(logic op, logic [KEY_W-1:0] bits, logic closes, bit drain);
		cmd_beat_t b;
		b.op         = op;
		b.bits       = bits;
		b.closes     = closes;
		b.wait_drain = drain;
		backlog.push_back(b);
		beats_queued++;
	endtask

	task automatic push_load(logic [KEY_W-1:0] bits, logic closes);
		push_beat(KIND_LOAD, bits, closes, $urandom_range(0, 39) == 0);
	endtask

	// key_bits and end_of_set carry noise on reads
	task automatic push_read();
		push_beat(KIND_READ, $urandom, 1'($urandom_range(0, 1)), $urandom_range(0, 39) == 0);
	endtask

	function automatic logic [KEY_W-1:0] pick_key(int style);
		logic [KEY_W-1:0] edges [11] = '{32'h0, 32'h1, 32'h7F, 32'h80, 32'hFF, 32'h7FFF,
			32'h8000, 32'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
		logic [KEY_W-1:0] k;
		case (style)
			0: k = $urandom;
			1: k = $urandom_range(0, 3);
			default: begin
				k = edges[$urandom_range(0, 10)];
				if ($urandom_range(0, 1) == 1 && k <= 32'hFFFF)
					k[31:16] = 16'($urandom_range(0, 65535));
			end
		endcase
		return k;
	endfunction

	// Wait until every command is taken and every read answered, then let
	// the last load finish.
	task automatic settle();
		do @(negedge clk);
		while (backlog.size() != 0 || cmd_valid || results_taken < reads_sent);
		repeat (8) @(negedge clk);
	endtask

	task automatic apb_write(logic reg_sel, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(logic [FMT_W-1:0] fmt, bit asc);
		logic [CFG_DATA_W-1:0] data;
		settle();
		data = $urandom;
		data[FMT_W-1:0] = fmt;
		apb_write(REG_KEY_FORMAT, data);
		cfg_fmt     = fmt;
		order_fresh = 1'b0;
		data = $urandom;
		data[0] = asc;
		apb_write(REG_ASCENDING, data);
		cfg_asc = asc;
		@(negedge clk);
	endtask

	task automatic build_set();
		int n;
		int style;
		int reads;
		int noise_at;
		int i;
		bit close_it;
		n        = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
		style    = $urandom_range(0, 2);
		close_it = ($urandom_range(0, 11) != 0);
		noise_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
		for (i = 0; i < n; i++) begin
			if (i == noise_at)
				push_read();
			push_load(pick_key(style), close_it && i == n - 1);
		end
		// sometimes abandon the set part way so the next load starts afresh
		reads = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n) : n + $urandom_range(0, 2);
		repeat (reads) push_read();
	endtask

	initial begin : run_phases
		int f;
		logic [FMT_W-1:0] fmt;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(negedge clk);

		// reset settings: signed 32 bit, ascending
		push_read();
		push_load(32'h7FFF_FFFF, 1'b0);
		push_load(32'h8000_0000, 1'b0);
		push_load(32'h0000_0000, 1'b0);
		push_load(32'hFFFF_FFFF, 1'b0);
		push_load(32'h8000_0000, 1'b0);
		push_read();
		push_load(32'h0000_0001, 1'b1);
		push_beat(KIND_READ, 32'h0, 1'b0, 1'b1);
		push_read();
		push_read();
		// switch format and direction half way through the set
		configure(FMT_U8, 1'b0);
		repeat (4) push_read();
		configure(FMT_S16, 1'b1);
		push_load(32'h1234_8000, 1'b0);
		push_load(32'h0000_7FFF, 1'b0);
		push_load(32'hFFFF_FFFF, 1'b0);
		push_load(32'h0001_8000, 1'b1);
		repeat (5) push_read();

		while (beats_queued < RANDOM_GOAL) begin
			f   = $urandom_range(0, 11);
			fmt = (f < 10) ? FMT_W'(f % 5) : FMT_W'($urandom_range(5, 7));
			configure(fmt, 1'($urandom_range(0, 1)));
			repeat ($urandom_range(1, 3)) build_set();
		end

		configure(FMT_U32, 1'b1);
		build_set();

		settle();
		repeat (32) @(negedge clk);
		if (due_entries.size() != 0)
			report_mismatch("results never returned", 0, due_entries.size());
		if (fault_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/sis_pkg.sv
sv/sis_ram.sv
sv/sis_cell.sv
sv/stable_index_sort.sv
verif/stable_index_sort_test.sv
